### rtl/tpe_pkg.sv
package tpe_pkg;

   // Register map of the processor.
   localparam int GLOBAL_REGS = 224;
   localparam int LOCAL_REGS  = 32;
   localparam int REG_COUNT   = GLOBAL_REGS + LOCAL_REGS;
   localparam int REG_DEPTH   = 256;
   localparam int IDX_W       = $clog2(REG_DEPTH);

   // Register that holds the pointer for indirect moves.
   localparam logic [IDX_W-1:0] GLOBAL_IDX = IDX_W'(GLOBAL_REGS);

   // Status word: bit 0 EQ, bit 1 LT, bit 2 GT, bit 3 carry.
   localparam logic [3:0] FLAG_EQ = 4'b0001;
   localparam logic [3:0] FLAG_LT = 4'b0010;
   localparam logic [3:0] FLAG_GT = 4'b0100;
   localparam logic [3:0] FLAG_CR = 4'b1000;

   typedef enum logic [1:0] {
      KIND_EXEC  = 2'd0,
      KIND_WRITE = 2'd1,
      KIND_SETPC = 2'd2
   } kind_type;

   typedef enum logic [7:0] {
      OP_HALT  = 8'd0,
      OP_NOOP  = 8'd1,
      OP_INT   = 8'd2,
      OP_WEQV  = 8'd3,
      OP_WEQR  = 8'd4,
      OP_WRLV  = 8'd5,
      OP_WRLR  = 8'd6,
      OP_WORV  = 8'd7,
      OP_WORR  = 8'd8,
      OP_MOVV  = 8'd9,
      OP_MOVR  = 8'd10,
      OP_MOVIR = 8'd11,
      OP_MOVRI = 8'd12,
      OP_ADDR  = 8'd13,
      OP_SUBR  = 8'd14,
      OP_LORR  = 8'd15,
      OP_ANDR  = 8'd16,
      OP_XORR  = 8'd17,
      OP_LSR   = 8'd18,
      OP_RSR   = 8'd19,
      OP_ADDV  = 8'd20,
      OP_SUBV  = 8'd21,
      OP_LORV  = 8'd22,
      OP_ANDV  = 8'd23,
      OP_XORV  = 8'd24,
      OP_LSV   = 8'd25,
      OP_RSV   = 8'd26,
      OP_WDOG  = 8'd27,
      OP_JMP   = 8'd28,
      OP_BEQ   = 8'd29,
      OP_BNE   = 8'd30,
      OP_BLT   = 8'd31,
      OP_BGT   = 8'd32,
      OP_BLE   = 8'd33,
      OP_BGE   = 8'd34,
      OP_BCR   = 8'd35
   } opcode_type;

   typedef struct packed {
      logic [1:0]       kind;
      logic [7:0]       opcode;
      logic [31:0]      src_a;
      logic [IDX_W-1:0] src_b;
      logic [IDX_W-1:0] dest_reg;
   } req_type;

   typedef struct packed {
      logic [15:0]        next_pc;
      logic               flag_eq;
      logic               flag_lt;
      logic               flag_gt;
      logic               flag_carry;
      logic               is_waiting;
      logic               reg_written;
      logic [IDX_W-1:0]   written_index;
      logic signed [31:0] written_value;
   } rsp_type;

   // Architectural state outside the register file.
   typedef struct packed {
      logic [15:0] pc;
      logic [3:0]  flags;
      logic        wait_active;
      logic [31:0] wait_target;
   } state_type;

   // One register file write.
   typedef struct packed {
      logic             en;
      logic [IDX_W-1:0] index;
      logic [31:0]      value;
   } wr_type;

endpackage

### rtl/tpe_regfile.sv
module tpe_regfile (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   rd_en,
   input  logic [7:0]             rd_addr_a,
   input  logic [7:0]             rd_addr_b,
   input  tpe_pkg::wr_type        wr,
   output logic [31:0]            rd_data_a,
   output logic [31:0]            rd_data_b,
   output logic [31:0]            irg
);
   import tpe_pkg::*;

   logic [31:0]          mem [REG_DEPTH];
   logic [REG_DEPTH-1:0] vld_ff;
   logic [31:0]          mem_a_ff;
   logic [31:0]          mem_b_ff;
   logic                 vld_a_ff;
   logic                 vld_b_ff;
   logic [IDX_W-1:0]     addr_a_ff;
   logic [IDX_W-1:0]     addr_b_ff;
   logic                 last_en_ff;
   logic [IDX_W-1:0]     last_idx_ff;
   logic [31:0]          last_val_ff;
   logic [31:0]          irg_ff;

   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem[wr.index] <= wr.value;
      end
      if (rd_en) begin
         mem_a_ff  <= mem[rd_addr_a];
         mem_b_ff  <= mem[rd_addr_b];
         vld_a_ff  <= vld_ff[rd_addr_a];
         vld_b_ff  <= vld_ff[rd_addr_b];
         addr_a_ff <= rd_addr_a;
         addr_b_ff <= rd_addr_b;
      end
      if (wr.en) begin
         last_idx_ff <= wr.index;
         last_val_ff <= wr.value;
      end
   end

   // Entries never written since reset read as zero.
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff     <= '0;
         last_en_ff <= 1'b0;
         irg_ff     <= '0;
      end else begin
         if (wr.en) begin
            vld_ff[wr.index] <= 1'b1;
            last_en_ff       <= 1'b1;
            if (wr.index == GLOBAL_IDX) begin
               irg_ff <= wr.value;
            end
         end
      end
   end

   // The read taken at the edge of the latest write misses that write, so the
   // latest write is forwarded over the stored read data.
   always_comb begin
      if (last_en_ff && last_idx_ff == addr_a_ff) begin
         rd_data_a = last_val_ff;
      end else begin
         rd_data_a = vld_a_ff ? mem_a_ff : '0;
      end
      if (last_en_ff && last_idx_ff == addr_b_ff) begin
         rd_data_b = last_val_ff;
      end else begin
         rd_data_b = vld_b_ff ? mem_b_ff : '0;
      end
   end

   assign irg = irg_ff;

endmodule

### rtl/tpe_exec.sv
module tpe_exec (
   input  tpe_pkg::req_type   req,
   input  logic [31:0]        va,
   input  logic [31:0]        vb,
   input  logic [31:0]        irg,
   input  tpe_pkg::state_type cur,
   output tpe_pkg::state_type nxt,
   output tpe_pkg::wr_type    wr
);
   import tpe_pkg::*;

   logic [31:0]      a;
   logic [31:0]      sh_amt;
   logic [31:0]      shl_res;
   logic [31:0]      sar_res;
   logic             irg_ok;
   logic             adv;
   logic             is_wait;
   logic             w_done;
   logic [31:0]      w_t;
   logic             wr_en;
   logic             set_fl;
   logic [IDX_W-1:0] wr_idx;
   logic [31:0]      wr_val;
   logic             take;

   assign a = req.src_a;

   always_comb begin
      nxt     = cur;
      adv     = 1'b0;
      is_wait = 1'b0;
      w_done  = 1'b0;
      w_t     = '0;
      wr_en   = 1'b0;
      set_fl  = 1'b0;
      wr_idx  = req.dest_reg;
      wr_val  = '0;
      take    = 1'b0;

      irg_ok  = !irg[31] && irg < 32'(REG_COUNT);
      sh_amt  = (req.opcode inside {OP_LSV, OP_RSV}) ? a : va;
      shl_res = (|sh_amt[31:5]) ? '0 : vb << sh_amt[4:0];
      sar_res = (|sh_amt[31:5]) ? {32{vb[31]}} : 32'($signed(vb) >>> sh_amt[4:0]);

      case (req.kind)
         KIND_EXEC: begin
            case (req.opcode)
               OP_NOOP, OP_INT, OP_WDOG: begin
                  adv = 1'b1;
               end
               OP_WEQV: begin
                  is_wait = 1'b1;
                  w_t     = a;
                  w_done  = vb == a;
               end
               OP_WEQR: begin
                  is_wait = 1'b1;
                  w_t     = va;
                  w_done  = vb == va;
               end
               OP_WRLV: begin
                  is_wait = 1'b1;
                  w_t     = cur.wait_active ? cur.wait_target : vb + a;
                  w_done  = $signed(vb) >= $signed(w_t);
               end
               OP_WRLR: begin
                  is_wait = 1'b1;
                  w_t     = cur.wait_active ? cur.wait_target : vb + va;
                  w_done  = $signed(vb) >= $signed(w_t);
               end
               OP_WORV: begin
                  is_wait = 1'b1;
                  w_t     = a;
                  w_done  = |(vb & a);
               end
               OP_WORR: begin
                  is_wait = 1'b1;
                  w_t     = va;
                  w_done  = |(vb & va);
               end
               OP_MOVV: begin
                  wr_en  = 1'b1;
                  wr_val = a;
               end
               OP_MOVR: begin
                  wr_en  = 1'b1;
                  wr_val = va;
               end
               // For indirect moves port A was addressed by the pointer
               // register (load) or by the destination field (store).
               OP_MOVIR: begin
                  wr_en  = irg_ok;
                  wr_val = va;
               end
               OP_MOVRI: begin
                  wr_en  = irg_ok;
                  wr_idx = irg[IDX_W-1:0];
                  wr_val = va;
               end
               OP_ADDR: begin wr_en = 1'b1; wr_val = va + vb; end
               OP_SUBR: begin wr_en = 1'b1; wr_val = vb - va; end
               OP_LORR: begin wr_en = 1'b1; wr_val = vb | va; end
               OP_ANDR: begin wr_en = 1'b1; wr_val = vb & va; end
               OP_XORR: begin wr_en = 1'b1; wr_val = vb ^ va; end
               OP_LSR:  begin wr_en = 1'b1; wr_val = shl_res; end
               OP_RSR:  begin wr_en = 1'b1; wr_val = sar_res; end
               OP_ADDV: begin wr_en = 1'b1; wr_val = vb + a; end
               OP_SUBV: begin wr_en = 1'b1; wr_val = vb - a; end
               OP_LORV: begin wr_en = 1'b1; wr_val = vb | a; end
               OP_ANDV: begin wr_en = 1'b1; wr_val = vb & a; end
               OP_XORV: begin wr_en = 1'b1; wr_val = vb ^ a; end
               OP_LSV:  begin wr_en = 1'b1; wr_val = shl_res; end
               OP_RSV:  begin wr_en = 1'b1; wr_val = sar_res; end
               OP_JMP: begin
                  nxt.pc = a[15:0];
               end
               OP_BEQ: take = |(cur.flags & FLAG_EQ);
               OP_BNE: take = !(|(cur.flags & FLAG_EQ));
               OP_BLT: take = |(cur.flags & FLAG_LT);
               OP_BGT: take = |(cur.flags & FLAG_GT);
               OP_BLE: take = |(cur.flags & (FLAG_EQ | FLAG_LT));
               OP_BGE: take = |(cur.flags & (FLAG_EQ | FLAG_GT));
               OP_BCR: take = |(cur.flags & FLAG_CR);
               default: ;
            endcase

            if (req.opcode inside {[OP_MOVV:OP_RSV]}) begin
               adv    = 1'b1;
               set_fl = wr_en;
            end
            if (req.opcode inside {[OP_BEQ:OP_BCR]}) begin
               if (take) begin
                  nxt.pc = a[15:0];
               end else begin
                  adv = 1'b1;
               end
            end
         end
         KIND_WRITE: begin
            wr_en  = 1'b1;
            wr_val = a;
         end
         KIND_SETPC: begin
            nxt.pc          = a[15:0];
            nxt.wait_active = 1'b0;
            nxt.wait_target = '0;
         end
         default: ;
      endcase

      // The first wait beat latches the target; a later one keeps it.
      if (is_wait) begin
         if (!cur.wait_active) begin
            nxt.wait_active = 1'b1;
            nxt.wait_target = w_t;
         end
         if (w_done) begin
            nxt.wait_active = 1'b0;
            adv             = 1'b1;
         end
      end

      if (adv) begin
         nxt.pc = cur.pc + 16'd1;
      end

      if (set_fl) begin
         if (wr_val == '0) begin
            nxt.flags = FLAG_EQ;
         end else if (wr_val[31]) begin
            nxt.flags = FLAG_LT;
         end else begin
            nxt.flags = FLAG_GT;
         end
      end

      wr.en    = wr_en;
      wr.index = wr_en ? wr_idx : '0;
      wr.value = wr_en ? wr_val : '0;
   end

endmodule

### rtl/timing_processor_execute_core.sv
// Executes one timing processor instruction, host register write or host
// program counter load per request beat and returns one response beat with
// the new program counter, the status flags, the wait status and the
// register written, if any. A request reads the register file at its
// accepting edge; the instruction then executes in the execute stage, and
// it commits and its response is registered when that stage advances, so
// the core takes one beat per clock while the response side is not stalled
// and no indirect move is held off. An indirect move (MOVIR or MOVRI) is
// held off while the instruction ahead of it may still be writing the
// pointer register 224, since that pointer addresses the register file
// read; the hold lasts until that instruction leaves the execute stage.
// All registers read as zero after reset; no clearing pass holds off requests.
module timing_processor_execute_core (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  tpe_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output tpe_pkg::rsp_type rsp_data
);
   import tpe_pkg::*;

   logic        s1_valid_ff;
   req_type     s1_ff;
   logic        s1_adv;
   logic        req_acc;
   logic        hazard;
   logic        rsp_valid_ff;
   rsp_type     rsp_ff;
   rsp_type     rsp_in;
   state_type   st_ff;
   state_type   st_in;
   wr_type      wr;
   wr_type      wr_commit;
   logic [7:0]  rd_addr_a;
   logic [31:0] va;
   logic [31:0] vb;
   logic [31:0] irg;

   // The stage ahead may change the pointer register that addresses an
   // indirect move's read.
   assign hazard = s1_valid_ff && req_data.kind == KIND_EXEC &&
                   (req_data.opcode == OP_MOVIR || req_data.opcode == OP_MOVRI) &&
                   ((s1_ff.dest_reg == GLOBAL_IDX && s1_ff.kind != KIND_SETPC) ||
                    (s1_ff.kind == KIND_EXEC && s1_ff.opcode == OP_MOVRI));

   assign s1_adv    = s1_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = (!s1_valid_ff || s1_adv) && !hazard;
   assign req_acc   = req_valid && req_ready;

   always_comb begin
      rd_addr_a = req_data.src_a[IDX_W-1:0];
      if (req_data.kind == KIND_EXEC && req_data.opcode == OP_MOVIR) begin
         rd_addr_a = irg[IDX_W-1:0];
      end else if (req_data.kind == KIND_EXEC && req_data.opcode == OP_MOVRI) begin
         rd_addr_a = req_data.dest_reg;
      end
   end

   assign wr_commit = s1_adv ? wr : '0;

   tpe_regfile u_regfile (
      .clock     (clock),
      .reset     (reset),
      .rd_en     (req_acc),
      .rd_addr_a (rd_addr_a),
      .rd_addr_b (req_data.src_b),
      .wr        (wr_commit),
      .rd_data_a (va),
      .rd_data_b (vb),
      .irg       (irg)
   );

   tpe_exec u_exec (
      .req (s1_ff),
      .va  (va),
      .vb  (vb),
      .irg (irg),
      .cur (st_ff),
      .nxt (st_in),
      .wr  (wr)
   );

   always_comb begin
      rsp_in.next_pc       = st_in.pc;
      rsp_in.flag_eq       = st_in.flags[0];
      rsp_in.flag_lt       = st_in.flags[1];
      rsp_in.flag_gt       = st_in.flags[2];
      rsp_in.flag_carry    = st_in.flags[3];
      rsp_in.is_waiting    = st_in.wait_active;
      rsp_in.reg_written   = wr.en;
      rsp_in.written_index = wr.index;
      rsp_in.written_value = wr.value;
   end

   always_ff @(posedge clock) begin
      if (req_acc) begin
         s1_ff <= req_data;
      end
      if (s1_adv) begin
         rsp_ff <= rsp_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         st_ff        <= '0;
      end else begin
         if (req_acc) begin
            s1_valid_ff <= 1'b1;
         end else if (s1_adv) begin
            s1_valid_ff <= 1'b0;
         end
         if (s1_adv) begin
            rsp_valid_ff <= 1'b1;
            st_ff        <= st_in;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

### test/testbench.sv
`timescale 1ns / 100ps

module testbench;
   import tpe_pkg::*;

   localparam bit [1:0] KIND_NONE    = 2'd3;
   localparam int       RANDOM_BEATS = 1700;
   localparam int       DRAIN_CYCLES = 8;
   localparam bit [31:0] BOUNDARY_VALUES [8] = '{
      32'h0000_0000, 32'h0000_0001, 32'h7FFF_FFFF, 32'h8000_0000,
      32'hFFFF_FFFF, 32'h0000_001F, 32'h0000_0020, 32'h0000_00E0
   };

   logic    clock = 1'b0;
   logic    reset;
   logic    req_valid;
   logic    req_ready;
   req_type req_data;
   logic    rsp_valid;
   logic    rsp_ready;
   rsp_type rsp_data;

   timing_processor_execute_core uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Architectural state of the processor as the tests expect it.
   bit [31:0] reg_model [REG_DEPTH];
   bit [15:0] pc_model;
   bit [3:0]  flags_model;
   bit        wait_pending;
   bit [31:0] wait_goal;
   bit [7:0]  wait_reg;
   bit        wr_en;
   bit [7:0]  wr_index;
   bit [31:0] wr_value;

   rsp_type pending_results [$];
   int      failures     = 0;
   int      beats_sent   = 0;
   bit      back_to_back = 1'b0;

   function void reset_model();
      foreach (reg_model[i]) reg_model[i] = '0;
      pc_model     = '0;
      flags_model  = '0;
      wait_pending = 1'b0;
      wait_goal    = '0;
      wait_reg     = '0;
   endfunction

   function void write_register(bit [7:0] idx, bit [31:0] v, bit update_flags);
      reg_model[idx] = v;
      wr_en    = 1'b1;
      wr_index = idx;
      wr_value = v;
      if (update_flags) begin
         if (v == 0)
            flags_model = FLAG_EQ;
         else if (v[31])
            flags_model = FLAG_LT;
         else
            flags_model = FLAG_GT;
      end
   endfunction

   function void advance_pc();
      pc_model = pc_model + 16'd1;
   endfunction

   function void branch_if(bit take, bit [31:0] target);
      if (take)
         pc_model = target[15:0];
      else
         advance_pc();
   endfunction

   // The first wait seen latches its target; any wait that is met releases it.
   function void hold_wait(bit [31:0] goal, bit [7:0] rb, bit met);
      if (!wait_pending) begin
         wait_pending = 1'b1;
         wait_goal    = goal;
         wait_reg     = rb;
      end
      if (met) begin
         wait_pending = 1'b0;
         advance_pc();
      end
   endfunction

   function bit [31:0] shift_left(bit [31:0] v, bit [31:0] n);
      return (n >= 32) ? 32'd0 : (v << n[4:0]);
   endfunction

   function bit [31:0] shift_right(bit [31:0] v, bit [31:0] n);
      if (n >= 32)
         return {32{v[31]}};
      return $signed(v) >>> n[4:0];
   endfunction

   function automatic rsp_type execute_step(req_type item);
      bit [31:0] a, va, vb, ptr, goal;
      bit [7:0]  ra, rb, rd;
      bit        ptr_ok;
      rsp_type   res;
      a      = item.src_a;
      ra     = a[7:0];
      rb     = item.src_b;
      rd     = item.dest_reg;
      va     = reg_model[ra];
      vb     = reg_model[rb];
      ptr    = reg_model[GLOBAL_IDX];
      ptr_ok = !ptr[31] && ptr < REG_COUNT && ptr < REG_DEPTH;
      wr_en    = 1'b0;
      wr_index = '0;
      wr_value = '0;
      case (item.kind)
         KIND_EXEC: begin
            case (item.opcode)
               OP_HALT: ;
               OP_NOOP, OP_INT, OP_WDOG: advance_pc();
               OP_WEQV: hold_wait(a, rb, vb == a);
               OP_WEQR: hold_wait(va, rb, vb == va);
               OP_WRLV, OP_WRLR: begin
                  goal = wait_pending ? wait_goal
                                      : vb + ((item.opcode == OP_WRLV) ? a : va);
                  hold_wait(goal, rb, $signed(vb) >= $signed(goal));
               end
               OP_WORV: hold_wait(a, rb, (vb & a) != 0);
               OP_WORR: hold_wait(va, rb, (vb & va) != 0);
               OP_MOVV: begin write_register(rd, a, 1'b1); advance_pc(); end
               OP_MOVR: begin write_register(rd, va, 1'b1); advance_pc(); end
               OP_MOVIR: begin
                  if (ptr_ok) write_register(rd, reg_model[ptr[7:0]], 1'b1);
                  advance_pc();
               end
               OP_MOVRI: begin
                  if (ptr_ok) write_register(ptr[7:0], reg_model[rd], 1'b1);
                  advance_pc();
               end
               OP_ADDR: begin write_register(rd, va + vb, 1'b1); advance_pc(); end
               OP_SUBR: begin write_register(rd, vb - va, 1'b1); advance_pc(); end
               OP_LORR: begin write_register(rd, vb | va, 1'b1); advance_pc(); end
               OP_ANDR: begin write_register(rd, vb & va, 1'b1); advance_pc(); end
               OP_XORR: begin write_register(rd, vb ^ va, 1'b1); advance_pc(); end
               OP_LSR: begin
                  write_register(rd, shift_left(vb, va), 1'b1);
                  advance_pc();
               end
               OP_RSR: begin
                  write_register(rd, shift_right(vb, va), 1'b1);
                  advance_pc();
               end
               OP_ADDV: begin write_register(rd, vb + a, 1'b1); advance_pc(); end
               OP_SUBV: begin write_register(rd, vb - a, 1'b1); advance_pc(); end
               OP_LORV: begin write_register(rd, vb | a, 1'b1); advance_pc(); end
               OP_ANDV: begin write_register(rd, vb & a, 1'b1); advance_pc(); end
               OP_XORV: begin write_register(rd, vb ^ a, 1'b1); advance_pc(); end
               OP_LSV: begin
                  write_register(rd, shift_left(vb, a), 1'b1);
                  advance_pc();
               end
               OP_RSV: begin
                  write_register(rd, shift_right(vb, a), 1'b1);
                  advance_pc();
               end
               OP_JMP: pc_model = a[15:0];
               OP_BEQ: branch_if((flags_model & FLAG_EQ) != 0, a);
               OP_BNE: branch_if((flags_model & FLAG_EQ) == 0, a);
               OP_BLT: branch_if((flags_model & FLAG_LT) != 0, a);
               OP_BGT: branch_if((flags_model & FLAG_GT) != 0, a);
               OP_BLE: branch_if((flags_model & (FLAG_EQ | FLAG_LT)) != 0, a);
               OP_BGE: branch_if((flags_model & (FLAG_EQ | FLAG_GT)) != 0, a);
               OP_BCR: branch_if((flags_model & FLAG_CR) != 0, a);
               default: ;
            endcase
         end
         KIND_WRITE: write_register(rd, a, 1'b0);
         KIND_SETPC: begin
            pc_model     = a[15:0];
            wait_pending = 1'b0;
            wait_goal    = '0;
         end
         default: ;
      endcase
      res.next_pc       = pc_model;
      res.flag_eq       = (flags_model & FLAG_EQ) != 0;
      res.flag_lt       = (flags_model & FLAG_LT) != 0;
      res.flag_gt       = (flags_model & FLAG_GT) != 0;
      res.flag_carry    = (flags_model & FLAG_CR) != 0;
      res.is_waiting    = wait_pending;
      res.reg_written   = wr_en;
      res.written_index = wr_index;
      res.written_value = wr_value;
      return res;
   endfunction

   function automatic req_type make_req(bit [1:0] kind, bit [7:0] op, bit [31:0] a,
                                        bit [7:0] b, bit [7:0] d);
      req_type item;
      item.kind     = kind;
      item.opcode   = op;
      item.src_a    = a;
      item.src_b    = b;
      item.dest_reg = d;
      return item;
   endfunction

   // Mostly short gaps, now and then a long one.
   function int idle_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55)
         return 0;
      if (r < 90)
         return $urandom_range(1, 3);
      return $urandom_range(4, 24);
   endfunction

   function bit [31:0] random_value();
      case ($urandom_range(0, 5))
         0: return BOUNDARY_VALUES[$urandom_range(0, 7)];
         1: return $urandom_range(0, 40);
         2: return 32'd0 - $urandom_range(1, 40);
         default: return $urandom();
      endcase
   endfunction

   // Register indexes crowd a few registers so that values get reused.
   function bit [7:0] pick_index();
      int r;
      r = $urandom_range(0, 9);
      if (r < 6)
         return $urandom_range(0, 7);
      if (r == 6)
         return GLOBAL_IDX;
      if (r == 7)
         return $urandom_range(248, 255);
      return $urandom_range(0, 255);
   endfunction

   function automatic req_type random_req();
      int        r;
      bit [31:0] a;
      bit [7:0]  d;
      r = $urandom_range(0, 99);
      if (r < 8) begin
         d = pick_index();
         a = (d == GLOBAL_IDX && $urandom_range(0, 1)) ? $urandom_range(0, 255)
                                                       : random_value();
         return make_req(KIND_WRITE, $urandom(), a, $urandom(), d);
      end
      if (r < 11)
         return make_req(KIND_SETPC, $urandom(), $urandom(), $urandom(), $urandom());
      if (r < 12)
         return make_req(KIND_NONE, $urandom(), $urandom(), $urandom(), $urandom());
      a = random_value();
      if ($urandom_range(0, 1))
         a[7:0] = pick_index();
      return make_req(KIND_EXEC,
                      ($urandom_range(0, 19) == 0) ? $urandom_range(36, 255)
                                                   : $urandom_range(0, 35),
                      a, pick_index(), pick_index());
   endfunction

   // Entered and left just after a falling edge.
   task automatic send_beat(req_type item);
      int gap;
      gap = back_to_back ? 0 : idle_gap();
      if (gap > 0) begin
         req_valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_data  = item;
      req_valid = 1'b1;
      do @(posedge clock); while (req_ready !== 1'b1);
      pending_results.push_back(execute_step(item));
      beats_sent++;
      @(negedge clock);
   endtask

   task automatic run_wait_sequence();
      bit [7:0]  op, rb;
      bit [31:0] a, fill;
      req_type   waiter;
      op = 8'(OP_WEQV) + 8'($urandom_range(0, 5));
      rb = $urandom_range(0, 7);
      a  = random_value();
      if (op == OP_WEQR || op == OP_WRLR || op == OP_WORR)
         a[7:0] = $urandom_range(0, 7);
      waiter = make_req(KIND_EXEC, op, a, rb, $urandom());
      send_beat(waiter);
      repeat ($urandom_range(0, 2)) send_beat(random_req());
      case (op)
         OP_WEQV: fill = a;
         OP_WEQR: fill = reg_model[a[7:0]];
         OP_WRLV, OP_WRLR: fill = 32'h7FFF_FFFF;
         default: fill = 32'hFFFF_FFFF;
      endcase
      send_beat(make_req(KIND_WRITE, $urandom(), fill, $urandom(), rb));
      send_beat(waiter);
   endtask

   // A pointer load followed, mostly back to back, by an indirect move exercises the hold-off.
   task automatic run_pointer_sequence();
      bit [31:0] ptr;
      bit        saved;
      case ($urandom_range(0, 9))
         0: ptr = REG_COUNT;
         1: ptr = 32'h8000_0000 | $urandom();
         2: ptr = $urandom();
         default: ptr = $urandom_range(0, 255);
      endcase
      saved        = back_to_back;
      back_to_back = $urandom_range(0, 2) != 0;
      send_beat(make_req(KIND_WRITE, $urandom(), ptr, $urandom(), GLOBAL_IDX));
      send_beat(make_req(KIND_EXEC, $urandom_range(0, 1) ? OP_MOVIR : OP_MOVRI,
                         $urandom(), $urandom(), pick_index()));
      back_to_back = saved;
   endtask

   task automatic test_host_access();
      send_beat(make_req(KIND_WRITE, 8'hFF, 32'h8000_0000, 8'hFF, 8'd0));
      send_beat(make_req(KIND_WRITE, 8'h00, 32'hFFFF_FFFF, 8'h00, 8'd255));
      send_beat(make_req(KIND_WRITE, OP_MOVIR, 32'd255, 8'd0, GLOBAL_IDX));
      send_beat(make_req(KIND_SETPC, OP_HALT, 32'h1234_FFFF, 8'hFF, 8'hFF));
      send_beat(make_req(KIND_NONE, 8'hFF, 32'hFFFF_FFFF, 8'hFF, 8'hFF));
   endtask

   task automatic test_each_opcode();
      for (int op = OP_HALT; op <= OP_BCR; op++)
         send_beat(make_req(KIND_EXEC, 8'(op), BOUNDARY_VALUES[op % 8],
                            (op % 2) ? 8'd255 : 8'd0, 8'(op + 16)));
   endtask

   task automatic test_corner_cases();
      back_to_back = 1'b1;
      // The program counter wraps from 0xFFFF to zero.
      send_beat(make_req(KIND_SETPC, OP_NOOP, 32'h0000_FFFF, 8'd0, 8'd0));
      send_beat(make_req(KIND_EXEC, OP_NOOP, 32'd0, 8'd0, 8'd0));
      send_beat(make_req(KIND_EXEC, OP_MOVV, 32'd32, 8'd0, 8'd6));
      send_beat(make_req(KIND_EXEC, OP_LSR, 32'd6, 8'd255, 8'd7));
      send_beat(make_req(KIND_EXEC, OP_RSV, 32'hFFFF_FFFF, 8'd0, 8'd8));
      send_beat(make_req(KIND_EXEC, OP_RSV, 32'd40, 8'd6, 8'd9));
      send_beat(make_req(KIND_EXEC, 8'hFF, 32'hFFFF_FFFF, 8'd6, 8'd6));
      send_beat(make_req(KIND_WRITE, OP_NOOP, 32'h8000_0000, 8'd0, GLOBAL_IDX));
      send_beat(make_req(KIND_EXEC, OP_MOVIR, 32'd0, 8'd0, 8'd10));
      send_beat(make_req(KIND_WRITE, OP_NOOP, REG_COUNT, 8'd0, GLOBAL_IDX));
      send_beat(make_req(KIND_EXEC, OP_MOVRI, 32'd0, 8'd0, 8'd6));
      send_beat(make_req(KIND_WRITE, OP_NOOP, 32'd6, 8'd0, GLOBAL_IDX));
      send_beat(make_req(KIND_EXEC, OP_MOVIR, 32'd0, 8'd0, 8'd11));
      send_beat(make_req(KIND_EXEC, OP_MOVRI, 32'd0, 8'd0, 8'd7));
      send_beat(make_req(KIND_EXEC, OP_ADDV, 32'd1, GLOBAL_IDX, GLOBAL_IDX));
      send_beat(make_req(KIND_EXEC, OP_MOVIR, 32'd0, 8'd0, 8'd12));
      // A wait that is not met holds the pc until the register catches up.
      send_beat(make_req(KIND_WRITE, OP_NOOP, 32'd5, 8'd0, 8'd2));
      send_beat(make_req(KIND_EXEC, OP_WEQV, 32'd6, 8'd2, 8'd0));
      send_beat(make_req(KIND_WRITE, OP_NOOP, 32'd6, 8'd0, 8'd2));
      send_beat(make_req(KIND_EXEC, OP_WEQV, 32'd6, 8'd2, 8'd0));
      // The wait target wraps negative, so the wait is met at once.
      send_beat(make_req(KIND_EXEC, OP_WRLV, 32'h7FFF_FFFF, 8'd2, 8'd0));
      send_beat(make_req(KIND_EXEC, OP_WORV, 32'd1, 8'd2, 8'd0));
      send_beat(make_req(KIND_SETPC, OP_NOOP, 32'h0000_0040, 8'd0, 8'd0));
      send_beat(make_req(KIND_EXEC, OP_BCR, 32'h0000_0100, 8'd0, 8'd0));
      back_to_back = 1'b0;
   endtask

   task automatic test_random_program();
      int last;
      int r;
      last = beats_sent + RANDOM_BEATS;
      while (beats_sent < last) begin
         if ($urandom_range(0, 49) == 0)
            back_to_back = !back_to_back;
         r = $urandom_range(0, 99);
         if (r < 75)
            send_beat(random_req());
         else if (r < 90)
            run_wait_sequence();
         else
            run_pointer_sequence();
      end
      back_to_back = 1'b0;
   endtask

   function void check_field(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
         $error("%s: expected %0h, got %0h", name, want, got);
         failures++;
      end
   endfunction

   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid === 1'b1 && rsp_ready === 1'b1) begin
         if (pending_results.size() == 0) begin
            $error("response beat with no instruction outstanding");
            failures++;
         end else begin
            want = pending_results.pop_front();
            check_field("next_pc", want.next_pc, rsp_data.next_pc);
            check_field("flag_eq", want.flag_eq, rsp_data.flag_eq);
            check_field("flag_lt", want.flag_lt, rsp_data.flag_lt);
            check_field("flag_gt", want.flag_gt, rsp_data.flag_gt);
            check_field("flag_carry", want.flag_carry, rsp_data.flag_carry);
            check_field("is_waiting", want.is_waiting, rsp_data.is_waiting);
            check_field("reg_written", want.reg_written, rsp_data.reg_written);
            check_field("written_index", want.written_index, rsp_data.written_index);
            check_field("written_value", want.written_value, rsp_data.written_value);
         end
      end
   end

   initial begin
      int stall;
      rsp_ready = 1'b0;
      @(negedge clock);
      forever begin
         rsp_ready = 1'b1;
         repeat (($urandom_range(0, 9) == 0) ? 80 : $urandom_range(1, 10))
            @(negedge clock);
         stall = idle_gap();
         if (stall > 0) begin
            rsp_ready = 1'b0;
            repeat (stall) @(negedge clock);
         end
      end
   end

   initial begin
      req_valid = 1'b0;
      req_data  = '0;
      reset     = 1'b1;
      reset_model();
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      test_host_access();
      test_each_opcode();
      test_corner_cases();
      test_random_program();
      req_valid = 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (failures == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

   initial begin
      #1_000_000;
      $display("TEST FAILED");
      $finish;
   end

endmodule
